// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port-level checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define AST_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, off during reset
`define AST_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== rtl/core/ffa_pkg.sv =====
// Package for the first-fit free-extent allocator: defaults, action and status codes.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package ffa_pkg;

  localparam int DEF_MAX_EXTENTS = 64;
  localparam int DEF_ADDR_BITS   = 32;
  localparam logic [31:0] ARENA_RESET = 32'd65536;

  // action codes
  localparam logic [2:0] ACT_INIT  = 3'd0;
  localparam logic [2:0] ACT_ALLOC = 3'd1;
  localparam logic [2:0] ACT_FREE  = 3'd2;
  localparam logic [2:0] ACT_ADD   = 3'd3;
  localparam logic [2:0] ACT_TAKE  = 3'd4;
  localparam logic [2:0] ACT_COUNT = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_OVERLAP = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/core/first_fit_free_list_allocator_unit.sv =====
// For alloc, free, add and nonzero take, a scan reads and evaluates extents in order, then decide and write
// follow; other actions skip the scan. An insert or remove then shifts the extents one at a time before
// the finish. A full table holds 64 entries by default. One request at a time: the scan and shift both go
// through the single extent memory. Reset (synchronous): the table is one extent (0, 65536); the boot
// state after reset loads memory entry 0, with busy high. The result strobe cannot be stalled.
// Extent table in a memory with one write and one registered read port; uses ffa_pkg.
`default_nettype none

module first_fit_free_list_allocator_unit
  import ffa_pkg::*;
#(
  parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
  parameter int ADDR_BITS   = DEF_ADDR_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        start,
  input  wire logic [2:0]  action,
  input  wire logic [31:0] length,
  input  wire logic [31:0] start_addr,
  output logic             busy,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      alloc_addr,
  output logic [6:0]       extent_count
);

  localparam int VW = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1;
  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [VW-1:0] LIMIT = {{(VW-1){1'b0}}, 1'b1} << ADDR_BITS;
  localparam logic [CW-1:0] MAXC  = CW'(MAX_EXTENTS);
  localparam logic [CW-1:0] ONE_C = {{(CW-1){1'b0}}, 1'b1};

  typedef struct packed {
    logic [VW-1:0] s;
    logic [VW-1:0] l;
  } ext_t;

  typedef enum logic [1:0] {OP_NONE, OP_REM, OP_INS} op_t;

  typedef enum logic [2:0] {
    S_BOOT, S_IDLE, S_SCAN_RD, S_SCAN_EV, S_DECIDE, S_WRITE, S_SHIFT, S_SH_WR
  } state_t;

  function automatic logic [VW-1:0] clip(input logic [31:0] sz);
    logic [VW-1:0] v;
    v = {{(VW-32){1'b0}}, sz};
    return (v > LIMIT) ? LIMIT : v;
  endfunction

  state_t        state;
  logic [31:0]   arena_size;
  logic [VW-1:0] arena_end;
  logic [CW-1:0] count;
  logic [2:0]    act;
  logic [VW-1:0] len;
  logic [VW-1:0] addr;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic [CW-1:0] k;
  ext_t          prev;
  ext_t          cur;
  logic          have_prev;
  logic          have_cur;
  logic          wr_pend;
  logic [CW-1:0] wr_addr;
  ext_t          wr_data;
  op_t           op;
  ext_t          ins_data;
  logic [1:0]    res_status;
  logic [VW-1:0] res_addr;

  // extent memory
  ext_t          mem [MAX_EXTENTS];
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  ext_t          mem_wdata;
  logic [IW-1:0] mem_raddr;
  ext_t          rd;

  logic [CW-1:0] k_dn;
  logic [CW-1:0] k_up;
  logic [VW-1:0] end_a;
  logic [VW-1:0] prev_end;
  logic [VW-1:0] bound;
  logic [VW-1:0] off;
  logic [VW-1:0] rem_l;
  logic [31:0]   count_wide;

  assign busy         = (state != S_IDLE);
  assign count_wide   = 32'(count);
  assign extent_count = count_wide[6:0];
  assign k_dn         = k - ONE_C;
  assign k_up         = k + ONE_C;
  assign end_a        = addr + len;
  assign prev_end     = prev.s + prev.l;
  assign bound        = have_cur ? cur.s : arena_end;
  assign off          = addr - cur.s;
  assign rem_l        = cur.l - len;

  // drive the memory ports from the sequencer state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr[IW-1:0];
    mem_wdata = wr_data;
    mem_raddr = idx[IW-1:0];
    case (state)
      S_BOOT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '{s: '0, l: clip(ARENA_RESET)};
      end
      S_WRITE: begin
        mem_we = wr_pend;
      end
      S_SHIFT: begin
        if (op == OP_INS) begin
          if (k == pos) begin
            mem_we    = 1'b1;
            mem_waddr = pos[IW-1:0];
            mem_wdata = ins_data;
          end else begin
            mem_raddr = k_dn[IW-1:0];
          end
        end else begin
          mem_raddr = k_up[IW-1:0];
        end
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k[IW-1:0];
        mem_wdata = rd;
      end
      default: begin
      end
    endcase
  end

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd <= mem[mem_raddr];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      arena_size <= ARENA_RESET;
    end else if (cfg_wr_en) begin
      arena_size <= cfg_wr_data;
    end
  end

  // sequencer: scan, decide, write, shift, finish
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BOOT;
      done      <= 1'b0;
      count     <= ONE_C;
      arena_end <= clip(ARENA_RESET);
      wr_pend   <= 1'b0;
      op        <= OP_NONE;
    end else begin
      done <= 1'b0;
      case (state)
        S_BOOT: begin
          state <= S_IDLE;
        end

        S_IDLE: begin
          if (start) begin
            act        <= action;
            len        <= {{(VW-32){1'b0}}, length};
            addr       <= {{(VW-32){1'b0}}, start_addr};
            idx        <= '0;
            have_prev  <= 1'b0;
            have_cur   <= 1'b0;
            wr_pend    <= 1'b0;
            wr_addr    <= '0;
            op         <= OP_NONE;
            res_status <= ST_OK;
            res_addr   <= '0;
            case (action)
              ACT_INIT: begin
                arena_end <= clip(arena_size);
                count     <= (clip(arena_size) != '0) ? ONE_C : '0;
                wr_pend   <= (clip(arena_size) != '0);
                wr_data   <= '{s: '0, l: clip(arena_size)};
                state     <= S_WRITE;
              end
              ACT_ALLOC, ACT_FREE, ACT_ADD: begin
                state <= S_SCAN_RD;
              end
              ACT_TAKE: begin
                state <= (length == 32'd0) ? S_WRITE : S_SCAN_RD;
              end
              default: begin
                state <= S_WRITE;
              end
            endcase
          end
        end

        S_SCAN_RD: begin
          if (idx == count) begin
            // ran off the table
            if (act == ACT_FREE || act == ACT_ADD) begin
              pos   <= count;
              state <= S_DECIDE;
            end else begin
              res_status <= ST_NOSPACE;
              state      <= S_WRITE;
            end
          end else begin
            state <= S_SCAN_EV;
          end
        end

        S_SCAN_EV: begin
          state <= S_SCAN_RD;
          idx   <= idx + ONE_C;
          case (act)
            ACT_ALLOC: begin
              if (rd.l >= len) begin
                cur   <= rd;
                pos   <= idx;
                state <= S_DECIDE;
              end
            end
            ACT_TAKE: begin
              if (addr >= rd.s && addr < rd.s + rd.l) begin
                cur   <= rd;
                pos   <= idx;
                state <= S_DECIDE;
              end
            end
            default: begin
              if (rd.s <= addr) begin
                prev      <= rd;
                have_prev <= 1'b1;
              end else begin
                cur      <= rd;
                have_cur <= 1'b1;
                pos      <= idx;
                state    <= S_DECIDE;
              end
            end
          endcase
        end

        S_DECIDE: begin
          state <= S_WRITE;
          case (act)
            ACT_ALLOC: begin
              res_addr <= cur.s;
              if (rem_l == '0) begin
                op <= OP_REM;
                k  <= pos;
              end else begin
                wr_pend <= 1'b1;
                wr_addr <= pos;
                wr_data <= '{s: cur.s + len, l: rem_l};
              end
            end
            ACT_TAKE: begin
              if (len > cur.l - off) begin
                res_status <= ST_NOSPACE;
              end else if (off == '0) begin
                if (rem_l == '0) begin
                  op <= OP_REM;
                  k  <= pos;
                end else begin
                  wr_pend <= 1'b1;
                  wr_addr <= pos;
                  wr_data <= '{s: cur.s + len, l: rem_l};
                end
              end else if (off + len == cur.l) begin
                wr_pend <= 1'b1;
                wr_addr <= pos;
                wr_data <= '{s: cur.s, l: off};
              end else if (count >= MAXC) begin
                res_status <= ST_FULL;
              end else begin
                // split: trim this extent, insert the tail after it
                wr_pend  <= 1'b1;
                wr_addr  <= pos;
                wr_data  <= '{s: cur.s, l: off};
                op       <= OP_INS;
                k        <= count;
                pos      <= pos + ONE_C;
                ins_data <= '{s: end_a, l: cur.l - off - len};
              end
            end
            default: begin
              if (end_a > LIMIT) begin
                res_status <= ST_NOSPACE;
              end else if (have_prev && prev_end > addr) begin
                res_status <= ST_OVERLAP;
              end else if (act == ACT_FREE && end_a > bound) begin
                res_status <= ST_OVERLAP;
              end else if (have_prev && prev_end == addr) begin
                // grow the lower neighbor, absorb the upper one if it touches
                wr_pend <= 1'b1;
                wr_addr <= pos - ONE_C;
                if (have_cur && end_a == cur.s) begin
                  wr_data <= '{s: prev.s, l: prev.l + len + cur.l};
                  op      <= OP_REM;
                  k       <= pos;
                end else begin
                  wr_data <= '{s: prev.s, l: prev.l + len};
                end
              end else if (have_cur && end_a == cur.s) begin
                wr_pend <= 1'b1;
                wr_addr <= pos;
                wr_data <= '{s: cur.s - len, l: cur.l + len};
              end else if (len != '0) begin
                if (count >= MAXC) begin
                  res_status <= ST_FULL;
                end else begin
                  op       <= OP_INS;
                  k        <= count;
                  ins_data <= '{s: addr, l: len};
                end
              end
            end
          endcase
        end

        S_WRITE: begin
          state <= S_SHIFT;
        end

        S_SHIFT: begin
          case (op)
            OP_INS: begin
              if (k == pos) begin
                count      <= count + ONE_C;
                done       <= 1'b1;
                status     <= res_status;
                alloc_addr <= res_addr[31:0];
                state      <= S_IDLE;
              end else begin
                state <= S_SH_WR;
              end
            end
            OP_REM: begin
              if (k_up == count) begin
                count      <= count - ONE_C;
                done       <= 1'b1;
                status     <= res_status;
                alloc_addr <= res_addr[31:0];
                state      <= S_IDLE;
              end else begin
                state <= S_SH_WR;
              end
            end
            default: begin
              done       <= 1'b1;
              status     <= res_status;
              alloc_addr <= res_addr[31:0];
              state      <= S_IDLE;
            end
          endcase
        end

        S_SH_WR: begin
          k     <= (op == OP_INS) ? k_dn : k_up;
          state <= S_SHIFT;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ffa_checker.sv =====
// Port-level checker for the allocator unit, bound to the top level.
// Depends on ffa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ffa_checker
  import ffa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [1:0]  status,
  input wire logic [31:0] alloc_addr
);

  // an accepted request always occupies the unit
  `AST_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // the result strobe comes as the unit goes idle
  `AST_IMPLY(a_done_idle, clk, rst, done, !busy)
  // the result strobe is never asserted twice in a row
  `AST_NEXT(a_done_pulse, clk, rst, done, !done)
  // failed requests return no address
  `AST_IMPLY(a_err_addr, clk, rst, done && (status != ST_OK), alloc_addr == 32'd0)

endmodule

bind first_fit_free_list_allocator_unit ffa_checker u_ffa_checker (.*);

`default_nettype wire

// ===== dv/tb_first_fit_free_list_allocator_unit.sv =====
// Testbench for first_fit_free_list_allocator_unit: directed and random requests, checked
// against a free-extent table predictor kept in a small scoreboard class.
// Depends on ffa_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module tb_first_fit_free_list_allocator_unit;
  import ffa_pkg::*;

  localparam int NUM_EXT = 64;
  localparam int WDOG_LIMIT = 5000;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] addr;
    logic [6:0]  count;
  } alloc_reply_t;

  // Free-extent table predictor and queue of pending replies
  class extent_scoreboard;
    logic [63:0] ext_base[NUM_EXT];
    logic [63:0] ext_len[NUM_EXT];
    int unsigned n_ext;
    logic [63:0] arena_end;
    logic [31:0] arena_size;
    alloc_reply_t pending[$];
    int errors;
    logic [1:0] last_status;
    logic [31:0] last_addr;

    function void reset_state();
      arena_size = ARENA_RESET;
      errors = 0;
      format_table();
    endfunction

    function void set_arena(logic [31:0] v);
      arena_size = v;
    endfunction

    function void format_table();
      logic [63:0] sz;
      sz = {32'd0, arena_size};
      if (sz > 64'h1_0000_0000) sz = 64'h1_0000_0000;
      arena_end = sz;
      for (int k = 0; k < NUM_EXT; k++) begin
        ext_base[k] = sz;
        ext_len[k] = 0;
      end
      n_ext = 0;
      if (sz != 0) begin
        ext_base[0] = 0;
        ext_len[0] = sz;
        n_ext = 1;
      end
    endfunction

    function void drop_extent(int unsigned i);
      for (int unsigned k = i; k + 1 < n_ext; k++) begin
        ext_base[k] = ext_base[k + 1];
        ext_len[k] = ext_len[k + 1];
      end
      n_ext--;
      ext_base[n_ext] = arena_end;
      ext_len[n_ext] = 0;
    endfunction

    function void open_extent(int unsigned i, logic [63:0] s, logic [63:0] l);
      for (int unsigned k = n_ext; k > i; k--) begin
        ext_base[k] = ext_base[k - 1];
        ext_len[k] = ext_len[k - 1];
      end
      ext_base[i] = s;
      ext_len[i] = l;
      n_ext++;
    endfunction

    // Return a range to free space, merging with neighbors
    function logic [1:0] release_range(logic [63:0] a, logic [63:0] len, bit check_upper);
      logic [63:0] fin;
      logic [63:0] bound;
      int unsigned i;
      fin = a + len;
      i = 0;
      while (i < n_ext && ext_base[i] <= a) i++;
      if (fin > 64'h1_0000_0000) return ST_NOSPACE;
      if (i > 0 && ext_base[i - 1] + ext_len[i - 1] > a) return ST_OVERLAP;
      if (check_upper) begin
        bound = (i < n_ext) ? ext_base[i] : arena_end;
        if (fin > bound) return ST_OVERLAP;
      end
      if (i > 0 && ext_base[i - 1] + ext_len[i - 1] == a) begin
        ext_len[i - 1] += len;
        if (i < n_ext && fin == ext_base[i]) begin
          ext_len[i - 1] += ext_len[i];
          drop_extent(i);
        end
      end else if (i < n_ext && fin == ext_base[i]) begin
        ext_base[i] -= len;
        ext_len[i] += len;
      end else if (len != 0) begin
        if (n_ext >= NUM_EXT) return ST_FULL;
        open_extent(i, a, len);
      end
      return ST_OK;
    endfunction

    // Carve a given range out of free space
    function logic [1:0] carve_range(logic [63:0] a, logic [63:0] len);
      int unsigned i;
      logic [63:0] off;
      if (len == 0) return ST_OK;
      for (i = 0; i < n_ext; i++)
        if (a >= ext_base[i] && a < ext_base[i] + ext_len[i]) break;
      if (i >= n_ext) return ST_NOSPACE;
      off = a - ext_base[i];
      if (len > ext_len[i] - off) return ST_NOSPACE;
      if (off == 0) begin
        ext_base[i] += len;
        ext_len[i] -= len;
        if (ext_len[i] == 0) drop_extent(i);
      end else if (off + len == ext_len[i]) begin
        ext_len[i] = off;
      end else begin
        if (n_ext >= NUM_EXT) return ST_FULL;
        open_extent(i + 1, a + len, ext_len[i] - off - len);
        ext_len[i] = off;
      end
      return ST_OK;
    endfunction

    function void note_request(logic [2:0] act, logic [31:0] len32, logic [31:0] a32);
      alloc_reply_t r;
      logic [63:0] len;
      logic [63:0] a;
      len = {32'd0, len32};
      a = {32'd0, a32};
      r.status = ST_OK;
      r.addr = '0;
      case (act)
        ACT_INIT: format_table();
        ACT_ALLOC: begin
          r.status = ST_NOSPACE;
          for (int unsigned i = 0; i < n_ext; i++) begin
            if (ext_len[i] >= len) begin
              r.addr = ext_base[i][31:0];
              ext_base[i] += len;
              ext_len[i] -= len;
              if (ext_len[i] == 0) drop_extent(i);
              r.status = ST_OK;
              break;
            end
          end
        end
        ACT_FREE: r.status = release_range(a, len, 1'b1);
        ACT_ADD:  r.status = release_range(a, len, 1'b0);
        ACT_TAKE: r.status = carve_range(a, len);
        default: ;
      endcase
      r.count = n_ext[6:0];
      last_status = r.status;
      last_addr = r.addr;
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] addr, logic [6:0] cnt);
      alloc_reply_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: status %0d addr %0h count %0d", st, addr, cnt);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (addr !== e.addr) begin
        $error("alloc_addr: expected %0h, got %0h", e.addr, addr);
        errors++;
      end
      if (cnt !== e.count) begin
        $error("extent_count: expected %0d, got %0d", e.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic start;
  logic [2:0] action;
  logic [31:0] length, start_addr;
  logic busy, done;
  logic [1:0] status;
  logic [31:0] alloc_addr;
  logic [6:0] extent_count;

  extent_scoreboard sb;
  bit calm;
  int idle_cycles;
  logic [31:0] held_addr[$];
  logic [31:0] held_len[$];

  first_fit_free_list_allocator_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .start(start), .action(action), .length(length), .start_addr(start_addr),
    .busy(busy), .done(done), .status(status), .alloc_addr(alloc_addr),
    .extent_count(extent_count)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Check replies before noting a request accepted on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(status, alloc_addr, extent_count);
      if (start && !busy) sb.note_request(action, length, start_addr);
    end
  end

  // Watchdog: stop when nothing moves for too long
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one request; called at a falling edge, returns at a falling edge once the request is accepted
  task automatic issue(logic [2:0] act, logic [31:0] len, logic [31:0] a);
    while (!calm && $urandom_range(0, 99) < 14) begin
      start = 0;
      @(negedge clk);
    end
    start = 1;
    action = act;
    length = len;
    start_addr = a;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drain outstanding replies, then write the arena size while idle
  task automatic write_arena(logic [31:0] v);
    start = 0;
    while (sb.pending.size() != 0 || busy) @(negedge clk);
    cfg_wr_en = 1;
    cfg_wr_data = v;
    @(negedge clk);
    sb.set_arena(v);
    cfg_wr_en = 0;
    cfg_wr_data = $urandom;
  endtask

  // Random traffic over one arena; mostly alloc/free pairs to build up fragmentation
  task automatic run_phase(logic [31:0] arena, int items);
    logic [31:0] scale, len, a;
    int p, k;
    write_arena(arena);
    issue(ACT_INIT, $urandom, $urandom);
    held_addr.delete();
    held_len.delete();
    scale = (arena >> 7) == 0 ? 32'd1 : (arena >> 7);
    for (int n = 0; n < items; n++) begin
      p = $urandom_range(0, 99);
      len = $urandom_range(0, 3) == 0 ? $urandom_range(0, scale * 8) :
            $urandom_range(1, scale);
      a = $urandom_range(0, arena == 0 ? 0 : arena - 1);
      if (p < 35) begin
        issue(ACT_ALLOC, len, $urandom);
        if (sb.last_status == ST_OK && len != 0) begin
          held_addr.push_back(sb.last_addr);
          held_len.push_back(len);
        end
      end else if (p < 62 && held_addr.size() != 0) begin
        k = $urandom_range(0, held_addr.size() - 1);
        issue(ACT_FREE, held_len[k], held_addr[k]);
        if (sb.last_status == ST_OK) begin
          held_addr.delete(k);
          held_len.delete(k);
        end
      end else if (p < 72) begin
        issue(ACT_TAKE, len, a);
      end else if (p < 78) begin
        issue(ACT_ADD, len, a);
      end else if (p < 84) begin
        issue(ACT_FREE, len, a);
      end else if (p < 88) begin
        issue(ACT_COUNT, $urandom, $urandom);
      end else if (p < 89) begin
        issue(ACT_INIT, $urandom, $urandom);
        held_addr.delete();
        held_len.delete();
      end else if (p < 97) begin
        // unconstrained fields, any action code but init
        issue(3'($urandom_range(1, 7)), $urandom, $urandom);
      end else begin
        // unused action codes
        issue(3'($urandom_range(6, 7)), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst = 1;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    start = 0;
    action = ACT_COUNT;
    length = 0;
    start_addr = 0;
    calm = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: reset table, edges of each action
    issue(ACT_COUNT, 0, 0);
    issue(ACT_ALLOC, 0, 0);
    issue(ACT_ALLOC, 65537, 0);
    issue(ACT_ALLOC, 100, 0);
    issue(ACT_FREE, 10, 50);
    issue(ACT_FREE, 2, 32'hFFFF_FFFF);
    issue(ACT_FREE, 0, 500);
    issue(ACT_TAKE, 0, 500);
    issue(ACT_TAKE, 10, 20);
    issue(ACT_TAKE, 10, 1000);
    issue(ACT_TAKE, 65436, 100);
    issue(ACT_ADD, 200, 0);
    issue(ACT_FREE, 100, 0);
    issue(ACT_ALLOC, 32'hFFFF_FFFF, 0);
    issue(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(3'd7, 0, 0);
    write_arena(0);
    issue(ACT_INIT, 0, 0);
    issue(ACT_ALLOC, 0, 0);
    issue(ACT_TAKE, 1, 0);
    issue(ACT_ADD, 16, 0);
    write_arena(32'hFFFF_FFFF);
    issue(ACT_INIT, 0, 0);
    issue(ACT_ALLOC, 32'hFFFF_FFFE, 0);
    issue(ACT_FREE, 32'hFFFF_FFFF, 0);

    // Random phases over several arena sizes; the second runs without gaps
    calm = 0;
    run_phase(1, 120);
    calm = 1;
    run_phase(65536, 300);
    calm = 0;
    run_phase(256, 300);
    run_phase(4096, 350);
    run_phase(32'hFFFF_FFFF, 300);
    run_phase($urandom_range(2, 20000), 380);

    start = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
